/* rtl/core/thcm_pkg.sv */
// Shared types, widths, codes and constant tables of the hit matcher.
// No dependencies; every other file of the block depends on this package.
package thcm_pkg;

	localparam int DEF_MAX_HITS = 128;

	localparam int POS_W   = 16;   // tracker x/y, cluster x/y input
	localparam int Z_W     = 17;   // tracker z and configured z positions
	localparam int DZ_W    = 18;   // difference of two z positions
	localparam int CPOS_W  = 20;   // cluster position scaled to mm
	localparam int NUM_W   = 34;   // projection numerator and projected point
	localparam int QUO_W   = 32;   // projection quotient magnitude
	localparam int DEN_W   = 17;   // projection denominator magnitude
	localparam int ENE_W   = 16;
	localparam int WIN_W   = 14;
	localparam int DIST_W  = 16;
	localparam int ANG_W   = 19;
	localparam int WCNT_W  = 8;
	localparam int BIDX_W  = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	localparam int ENTRY_W = POS_W + POS_W + Z_W;

	// Angle unit sizing.
	localparam int SQ_W         = 56;  // radicand of the square root
	localparam int ROOT_STEPS   = 28;
	localparam int ROOT_W       = 28;
	localparam int SQ_SHIFT     = 16;
	localparam int CORDIC_STEPS = 18;
	localparam int CX_W         = 47;
	localparam int CZ_W         = 25;
	localparam int ATAN_W       = 22;
	localparam int X_SHIFT      = 24;
	localparam int Y_SHIFT      = 16;
	localparam int STEP_CNT_W   = 5;

	localparam logic [ANG_W-1:0] ANGLE_MAX = 19'd368640;

	localparam logic signed [Z_W-1:0]  RST_TARGET_Z = -17'sd48000;
	localparam logic signed [Z_W-1:0]  RST_CALO_Z   = 17'sd42400;
	localparam logic [WIN_W-1:0]       RST_WINDOW   = 14'd640;
	localparam logic [DIST_W-1:0]      RST_MAX_DIST = 16'd16000;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_ADD     = 2'd1,
		OP_CLUSTER = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET_Z = 2'd0,
		CFG_CALO_Z   = 2'd1,
		CFG_WINDOW   = 2'd2,
		CFG_MAX_DIST = 2'd3
	} cfg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic ang_start;
		logic ang_track;
		logic rd;
		logic mul;
		logic div_start;
		logic win;
		logic sqd;
		logic upd;
		logic out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic table_empty;
		logic ang_done;
		logic den_zero;
		logic div_done;
		logic last_hit;
		logic found;
		logic out_free;
	} dp_stat_t;

	// Arctangent of 2^-i in degrees with 16 fraction bits.
	function automatic logic [ATAN_W-1:0] atan_deg(input logic [STEP_CNT_W-1:0] i);
		logic [ATAN_W-1:0] v;
		unique case (i)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740967;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234379;
			5'd5:  v = 22'd117304;
			5'd6:  v = 22'd58666;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Clamp a signed position to the 16 bit output range.
	function automatic logic [POS_W-1:0] sat_pos(input logic signed [NUM_W-1:0] v);
		logic [POS_W-1:0] r;
		if (v > NUM_W'(32767))
			r = 16'h7FFF;
		else if (v < -NUM_W'(32768))
			r = 16'h8000;
		else
			r = v[POS_W-1:0];
		return r;
	endfunction

endpackage

/* rtl/core/thcm_if.sv */
// Channel interfaces of the hit matcher: input items, result items and
// configuration writes. Depends on thcm_pkg for field widths.
interface thcm_in_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          op;
	logic signed [thcm_pkg::POS_W-1:0]   pos_x;
	logic signed [thcm_pkg::POS_W-1:0]   pos_y;
	logic signed [thcm_pkg::Z_W-1:0]     pos_z;
	logic [thcm_pkg::ENE_W-1:0]          energy;
	modport source (output valid, op, pos_x, pos_y, pos_z, energy, input ready);
	modport sink (input valid, op, pos_x, pos_y, pos_z, energy, output ready);
endinterface

interface thcm_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [thcm_pkg::POS_W-1:0]   cluster_x;
	logic signed [thcm_pkg::POS_W-1:0]   cluster_y;
	logic [thcm_pkg::ENE_W-1:0]          cluster_energy;
	logic [thcm_pkg::ANG_W-1:0]          cluster_angle;
	logic                                matched;
	logic [thcm_pkg::WCNT_W-1:0]         window_count;
	logic [thcm_pkg::BIDX_W-1:0]         best_index;
	logic [thcm_pkg::ANG_W-1:0]          track_angle;
	logic signed [thcm_pkg::POS_W-1:0]   projected_x;
	logic signed [thcm_pkg::POS_W-1:0]   projected_y;
	modport source (output valid, cluster_x, cluster_y, cluster_energy, cluster_angle,
		matched, window_count, best_index, track_angle, projected_x, projected_y,
		input ready);
	modport sink (input valid, cluster_x, cluster_y, cluster_energy, cluster_angle,
		matched, window_count, best_index, track_angle, projected_x, projected_y,
		output ready);
endinterface

interface thcm_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [thcm_pkg::CFG_IDX_W-1:0]      index;
	logic [thcm_pkg::CFG_DATA_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/thcm_div.sv */
// Two-lane restoring divider, one quotient bit per cycle in each lane.
// Depends on thcm_pkg for the operand widths.
module thcm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [thcm_pkg::QUO_W-1:0]  num_a,
	input  logic [thcm_pkg::QUO_W-1:0]  num_b,
	input  logic [thcm_pkg::DEN_W-1:0]  den,
	output logic                        done,
	output logic [thcm_pkg::QUO_W-1:0]  quo_a,
	output logic [thcm_pkg::QUO_W-1:0]  quo_b
);
	import thcm_pkg::*;

	localparam int CNT_W = $clog2(QUO_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] n_q   [2];
	logic [DEN_W-1:0] rem_q [2];
	logic [QUO_W-1:0] n_nx  [2];
	logic [DEN_W-1:0] rem_nx[2];
	logic [DEN_W:0]   trial [2];

	// The dividend shifts out at the top while quotient bits shift in below.
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			trial[l] = {rem_q[l], n_q[l][QUO_W-1]};
			if (trial[l] >= {1'b0, den_q}) begin
				rem_nx[l] = DEN_W'(trial[l] - {1'b0, den_q});
				n_nx[l]   = {n_q[l][QUO_W-2:0], 1'b1};
			end else begin
				rem_nx[l] = trial[l][DEN_W-1:0];
				n_nx[l]   = {n_q[l][QUO_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q    <= den;
			n_q[0]   <= num_a;
			n_q[1]   <= num_b;
			rem_q[0] <= '0;
			rem_q[1] <= '0;
		end else if (busy_q) begin
			for (int l = 0; l < 2; l++) begin
				n_q[l]   <= n_nx[l];
				rem_q[l] <= rem_nx[l];
			end
		end
	end

	assign done  = done_q;
	assign quo_a = n_q[0];
	assign quo_b = n_q[1];

endmodule

/* rtl/core/thcm_angle.sv */
// Polar angle unit: squares, bit-serial square root, then CORDIC vectoring
// one step per cycle. Depends on thcm_pkg for widths and the arctangent table.
module thcm_angle (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [thcm_pkg::CPOS_W-1:0] a,
	input  logic signed [thcm_pkg::CPOS_W-1:0] b,
	input  logic signed [thcm_pkg::DZ_W-1:0]   dz,
	output logic                              done,
	output logic [thcm_pkg::ANG_W-1:0]        angle
);
	import thcm_pkg::*;

	typedef enum logic [4:0] {
		A_IDLE = 5'b00001,
		A_SUM  = 5'b00010,
		A_ROOT = 5'b00100,
		A_ROT  = 5'b01000,
		A_FIN  = 5'b10000
	} aphase_t;

	aphase_t                   phase_q;
	logic [STEP_CNT_W-1:0]     cnt_q;
	logic                      done_q;
	logic [ANG_W-1:0]          angle_q;
	logic [2*CPOS_W-1:0]       asq_q, bsq_q;
	logic signed [2*CPOS_W-1:0] asq_nx, bsq_nx;
	logic signed [DZ_W-1:0]    dz_q;
	logic                      zero_q;
	logic [SQ_W-1:0]           rem_q, res_q, bit_q;
	logic [SQ_W-1:0]           rem_nx, res_nx, t_sum;
	logic [2*CPOS_W:0]         sq_sum;
	logic signed [CX_W-1:0]    x_q, y_q, dx, dy;
	logic signed [CZ_W-1:0]    z_q, za, z_rnd;
	logic [ANG_W-1:0]          angle_nx;

	// Full-width squares of the two coordinates.
	assign asq_nx = a * a;
	assign bsq_nx = b * b;

	assign sq_sum = {1'b0, asq_q} + {1'b0, bsq_q};

	always_comb begin
		t_sum = res_q + bit_q;
		if (rem_q >= t_sum) begin
			rem_nx = rem_q - t_sum;
			res_nx = (res_q >> 1) + bit_q;
		end else begin
			rem_nx = rem_q;
			res_nx = res_q >> 1;
		end
	end

	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign za = signed'({{(CZ_W-ATAN_W){1'b0}}, atan_deg(cnt_q)});
	assign z_rnd = (z_q + CZ_W'(8)) >>> 4;

	always_comb begin
		if (dz_q < 0 || zero_q)
			angle_nx = '0;
		else if (dz_q == '0)
			angle_nx = ANGLE_MAX;
		else if (z_q < 0)
			angle_nx = '0;
		else if ($unsigned(z_rnd) > CZ_W'(ANGLE_MAX))
			angle_nx = ANGLE_MAX;
		else
			angle_nx = z_rnd[ANG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= A_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				A_IDLE: begin
					if (start)
						phase_q <= A_SUM;
				end
				A_SUM: begin
					cnt_q   <= '0;
					phase_q <= A_ROOT;
				end
				A_ROOT: begin
					cnt_q <= cnt_q + STEP_CNT_W'(1);
					if (cnt_q == STEP_CNT_W'(ROOT_STEPS - 1)) begin
						cnt_q   <= '0;
						phase_q <= A_ROT;
					end
				end
				A_ROT: begin
					cnt_q <= cnt_q + STEP_CNT_W'(1);
					if (cnt_q == STEP_CNT_W'(CORDIC_STEPS - 1))
						phase_q <= A_FIN;
				end
				A_FIN: begin
					done_q  <= 1'b1;
					phase_q <= A_IDLE;
				end
				default: phase_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			A_IDLE: begin
				if (start) begin
					asq_q <= $unsigned(asq_nx);
					bsq_q <= $unsigned(bsq_nx);
					dz_q  <= dz;
				end
			end
			A_SUM: begin
				zero_q <= (sq_sum == '0);
				rem_q  <= SQ_W'({sq_sum, SQ_SHIFT'(0)});
				res_q  <= '0;
				bit_q  <= SQ_W'(1) << (2 * (ROOT_STEPS - 1));
			end
			A_ROOT: begin
				rem_q <= rem_nx;
				res_q <= res_nx;
				bit_q <= bit_q >> 2;
				if (cnt_q == STEP_CNT_W'(ROOT_STEPS - 1)) begin
					x_q <= {{(CX_W-DZ_W){dz_q[DZ_W-1]}}, dz_q} <<< X_SHIFT;
					y_q <= signed'(CX_W'({res_nx[ROOT_W-1:0], Y_SHIFT'(0)}));
					z_q <= '0;
				end
			end
			A_ROT: begin
				if (y_q >= 0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + za;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - za;
				end
			end
			A_FIN: angle_q <= angle_nx;
			default: ;
		endcase
	end

	assign done  = done_q;
	assign angle = angle_q;

endmodule

/* rtl/core/thcm_dp.sv */
// Datapath of the hit matcher: configuration, hit table memory, projection,
// window and distance tests, best-hit tracking and the result register.
// Depends on thcm_pkg, thcm_div and thcm_angle.
module thcm_dp #(
	parameter int MAX_HITS = thcm_pkg::DEF_MAX_HITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  thcm_pkg::dp_cmd_t                    cmd,
	output thcm_pkg::dp_stat_t                   stat,
	input  logic [1:0]                           in_op,
	input  logic signed [thcm_pkg::POS_W-1:0]    in_x,
	input  logic signed [thcm_pkg::POS_W-1:0]    in_y,
	input  logic signed [thcm_pkg::Z_W-1:0]      in_z,
	input  logic [thcm_pkg::ENE_W-1:0]           in_energy,
	input  logic                                 cfg_we,
	input  logic [thcm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [thcm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic signed [thcm_pkg::POS_W-1:0]    cluster_x,
	output logic signed [thcm_pkg::POS_W-1:0]    cluster_y,
	output logic [thcm_pkg::ENE_W-1:0]           cluster_energy,
	output logic [thcm_pkg::ANG_W-1:0]           cluster_angle,
	output logic                                 matched,
	output logic [thcm_pkg::WCNT_W-1:0]          window_count,
	output logic [thcm_pkg::BIDX_W-1:0]          best_index,
	output logic [thcm_pkg::ANG_W-1:0]           track_angle,
	output logic signed [thcm_pkg::POS_W-1:0]    projected_x,
	output logic signed [thcm_pkg::POS_W-1:0]    projected_y
);
	import thcm_pkg::*;

	localparam int CW = $clog2(MAX_HITS + 1);
	localparam int IW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;

	// Configuration.
	logic signed [Z_W-1:0] tz_q, cz_q;
	logic [WIN_W-1:0]      win_q;
	logic [DIST_W-1:0]     maxd_q;

	// Table.
	logic [ENTRY_W-1:0]    mem [MAX_HITS];
	logic [ENTRY_W-1:0]    rd_q;
	logic [CW-1:0]         count_q;

	// Cluster context.
	logic signed [CPOS_W-1:0] cx_q, cy_q, cx_nx, cy_nx;
	logic signed [DZ_W-1:0]   dzc_q;
	logic [ENE_W-1:0]         ene_q;
	logic [2*DIST_W-1:0]      bests_q;
	logic [CW-1:0]            idx_q;
	logic [WCNT_W-1:0]        wcnt_q;
	logic                     found_q;
	logic [CW-1:0]            bidx_q;
	logic signed [NUM_W-1:0]  bpx_q, bpy_q;
	logic signed [POS_W-1:0]  bx_q, by_q;
	logic signed [Z_W-1:0]    bz_q;
	logic [ANG_W-1:0]         cang_q, tang_q;
	logic                     trk_q;

	// Per-hit pipeline.
	logic signed [POS_W-1:0]  hx_q, hy_q;
	logic signed [Z_W-1:0]    hz_q;
	logic signed [DZ_W-1:0]   den_q;
	logic signed [NUM_W-1:0]  numx_q, numy_q, absx, absy;
	logic [DEN_W-1:0]         absd;
	logic                     sx_q, sy_q;
	logic signed [NUM_W-1:0]  px_q, py_q, px_nx, py_nx;
	logic signed [NUM_W:0]    ex, ey, aex, aey;
	logic [WIN_W-1:0]         ex_q, ey_q;
	logic                     inwin_q;
	logic [2*WIN_W:0]         s_q;

	// Units.
	logic                     div_done, ang_done;
	logic [QUO_W-1:0]         quo_x, quo_y;
	logic [ANG_W-1:0]         ang_res;
	logic signed [CPOS_W-1:0] ang_a, ang_b;
	logic signed [DZ_W-1:0]   ang_dz;

	// Result register.
	logic                     ovalid_q;

	assign cx_nx = ({{(CPOS_W-POS_W){in_x[POS_W-1]}}, in_x} <<< 3)
		+ ({{(CPOS_W-POS_W){in_x[POS_W-1]}}, in_x} <<< 1);
	assign cy_nx = ({{(CPOS_W-POS_W){in_y[POS_W-1]}}, in_y} <<< 3)
		+ ({{(CPOS_W-POS_W){in_y[POS_W-1]}}, in_y} <<< 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tz_q    <= RST_TARGET_Z;
			cz_q    <= RST_CALO_Z;
			win_q   <= RST_WINDOW;
			maxd_q  <= RST_MAX_DIST;
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_TARGET_Z: tz_q   <= signed'(cfg_data[Z_W-1:0]);
					CFG_CALO_Z:   cz_q   <= signed'(cfg_data[Z_W-1:0]);
					CFG_WINDOW:   win_q  <= cfg_data[WIN_W-1:0];
					CFG_MAX_DIST: maxd_q <= cfg_data[DIST_W-1:0];
				endcase
			end
			if (cmd.accept) begin
				if (op_t'(in_op) == OP_CLEAR)
					count_q <= '0;
				else if (op_t'(in_op) == OP_ADD && count_q < CW'(MAX_HITS))
					count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && op_t'(in_op) == OP_ADD && count_q < CW'(MAX_HITS))
			mem[count_q[IW-1:0]] <= {in_z, in_y, in_x};
		if (cmd.rd)
			rd_q <= mem[idx_q[IW-1:0]];
	end

	// Projection numerator and denominator for the hit just read.
	assign absx = numx_q[NUM_W-1] ? -numx_q : numx_q;
	assign absy = numy_q[NUM_W-1] ? -numy_q : numy_q;
	assign absd = den_q[DZ_W-1] ? DEN_W'(-den_q) : DEN_W'(den_q);

	thcm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num_a  (absx[QUO_W-1:0]),
		.num_b  (absy[QUO_W-1:0]),
		.den    (absd),
		.done   (div_done),
		.quo_a  (quo_x),
		.quo_b  (quo_y)
	);

	// Quotient truncates toward zero, so the sign goes on the magnitude.
	assign px_nx = sx_q ? -signed'(NUM_W'(quo_x)) : signed'(NUM_W'(quo_x));
	assign py_nx = sy_q ? -signed'(NUM_W'(quo_y)) : signed'(NUM_W'(quo_y));
	assign ex  = {px_nx[NUM_W-1], px_nx} - (NUM_W+1)'(cx_q);
	assign ey  = {py_nx[NUM_W-1], py_nx} - (NUM_W+1)'(cy_q);
	assign aex = ex[NUM_W] ? -ex : ex;
	assign aey = ey[NUM_W] ? -ey : ey;

	assign ang_a  = cmd.ang_track ? CPOS_W'(bx_q) : cx_q;
	assign ang_b  = cmd.ang_track ? CPOS_W'(by_q) : cy_q;
	assign ang_dz = cmd.ang_track ? (DZ_W'(bz_q) - DZ_W'(tz_q)) : dzc_q;

	thcm_angle u_angle (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.ang_start),
		.a      (ang_a),
		.b      (ang_b),
		.dz     (ang_dz),
		.done   (ang_done),
		.angle  (ang_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.accept && op_t'(in_op) == OP_CLUSTER)
				found_q <= 1'b0;
			else if (cmd.upd && inwin_q && {3'b0, s_q} < bests_q)
				found_q <= 1'b1;
			if (cmd.out_load)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && op_t'(in_op) == OP_CLUSTER) begin
			cx_q    <= cx_nx;
			cy_q    <= cy_nx;
			ene_q   <= in_energy;
			dzc_q   <= DZ_W'(cz_q) - DZ_W'(tz_q);
			bests_q <= maxd_q * maxd_q;
			idx_q   <= '0;
			wcnt_q  <= '0;
			bidx_q  <= '0;
			bpx_q   <= '0;
			bpy_q   <= '0;
			tang_q  <= '0;
		end
		if (cmd.ang_start)
			trk_q <= cmd.ang_track;
		if (ang_done) begin
			if (trk_q)
				tang_q <= ang_res;
			else
				cang_q <= ang_res;
		end
		if (cmd.mul) begin
			hx_q    <= rd_q[POS_W-1:0];
			hy_q    <= rd_q[2*POS_W-1:POS_W];
			hz_q    <= rd_q[ENTRY_W-1:2*POS_W];
			den_q   <= DZ_W'(signed'(rd_q[ENTRY_W-1:2*POS_W])) - DZ_W'(tz_q);
			numx_q  <= signed'(rd_q[POS_W-1:0]) * dzc_q;
			numy_q  <= signed'(rd_q[2*POS_W-1:POS_W]) * dzc_q;
			inwin_q <= 1'b0;
		end
		if (cmd.div_start) begin
			sx_q <= numx_q[NUM_W-1] ^ den_q[DZ_W-1];
			sy_q <= numy_q[NUM_W-1] ^ den_q[DZ_W-1];
		end
		if (cmd.win) begin
			px_q    <= px_nx;
			py_q    <= py_nx;
			ex_q    <= aex[WIN_W-1:0];
			ey_q    <= aey[WIN_W-1:0];
			inwin_q <= (aex < (NUM_W+1)'(win_q)) && (aey < (NUM_W+1)'(win_q));
		end
		if (cmd.sqd)
			s_q <= (2*WIN_W+1)'(ex_q * ex_q) + (2*WIN_W+1)'(ey_q * ey_q);
		if (cmd.upd) begin
			idx_q <= idx_q + CW'(1);
			if (inwin_q) begin
				if (wcnt_q != '1)
					wcnt_q <= wcnt_q + WCNT_W'(1);
				if ({3'b0, s_q} < bests_q) begin
					bests_q <= {3'b0, s_q};
					bidx_q  <= idx_q;
					bpx_q   <= px_q;
					bpy_q   <= py_q;
					bx_q    <= hx_q;
					by_q    <= hy_q;
					bz_q    <= hz_q;
				end
			end
		end
		if (cmd.out_load) begin
			cluster_x      <= sat_pos(NUM_W'(cx_q));
			cluster_y      <= sat_pos(NUM_W'(cy_q));
			cluster_energy <= ene_q;
			cluster_angle  <= cang_q;
			matched        <= (wcnt_q != '0);
			window_count   <= wcnt_q;
			best_index     <= (32'(bidx_q) > 32'd127) ? BIDX_W'(127) : BIDX_W'(bidx_q);
			track_angle    <= tang_q;
			projected_x    <= sat_pos(bpx_q);
			projected_y    <= sat_pos(bpy_q);
		end
	end

	assign out_valid = ovalid_q;

	assign stat.table_empty = (count_q == '0);
	assign stat.ang_done    = ang_done;
	assign stat.den_zero    = (den_q == '0);
	assign stat.div_done    = div_done;
	assign stat.last_hit    = (idx_q + CW'(1) == count_q);
	assign stat.found       = found_q;
	assign stat.out_free    = !ovalid_q || out_ready;

endmodule

/* rtl/core/thcm_ctrl.sv */
// Controller of the hit matcher: sequences cluster angle, the table scan
// and the track angle. Depends on thcm_pkg for the command/status structs.
module thcm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [1:0]           in_op,
	output logic                 in_ready,
	output thcm_pkg::dp_cmd_t    cmd,
	input  thcm_pkg::dp_stat_t   stat
);
	import thcm_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_CANG_GO = 13'b0000000000010,
		S_CANG_WT = 13'b0000000000100,
		S_RD      = 13'b0000000001000,
		S_MUL     = 13'b0000000010000,
		S_CHK     = 13'b0000000100000,
		S_DIV     = 13'b0000001000000,
		S_WIN     = 13'b0000010000000,
		S_DIST    = 13'b0000100000000,
		S_UPD     = 13'b0001000000000,
		S_TANG_GO = 13'b0010000000000,
		S_TANG_WT = 13'b0100000000000,
		S_OUT     = 13'b1000000000000
	} state_t;

	state_t state_q, state_nx;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (op_t'(in_op) == OP_CLUSTER)
						state_nx = S_CANG_GO;
				end
			end
			S_CANG_GO: begin
				cmd.ang_start = 1'b1;
				state_nx      = S_CANG_WT;
			end
			S_CANG_WT: begin
				if (stat.ang_done)
					state_nx = stat.table_empty ? S_OUT : S_RD;
			end
			S_RD: begin
				cmd.rd   = 1'b1;
				state_nx = S_MUL;
			end
			S_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = S_CHK;
			end
			S_CHK: begin
				if (stat.den_zero) begin
					state_nx = S_UPD;
				end else begin
					cmd.div_start = 1'b1;
					state_nx      = S_DIV;
				end
			end
			S_DIV: begin
				if (stat.div_done)
					state_nx = S_WIN;
			end
			S_WIN: begin
				cmd.win  = 1'b1;
				state_nx = S_DIST;
			end
			S_DIST: begin
				cmd.sqd  = 1'b1;
				state_nx = S_UPD;
			end
			S_UPD: begin
				cmd.upd  = 1'b1;
				state_nx = stat.last_hit ? S_TANG_GO : S_RD;
			end
			S_TANG_GO: begin
				if (stat.found) begin
					cmd.ang_start = 1'b1;
					cmd.ang_track = 1'b1;
					state_nx      = S_TANG_WT;
				end else begin
					state_nx = S_OUT;
				end
			end
			S_TANG_WT: begin
				if (stat.ang_done)
					state_nx = S_OUT;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nx;
	end

endmodule

/* rtl/core/tracker_calorimeter_hit_matcher.sv */
// Top level of the tracker / calorimeter hit matcher: controller, datapath
// and channel wiring. Depends on thcm_pkg, thcm_if, thcm_ctrl and thcm_dp.
//
//   channel  | dir | payload                                    | accepted when
//   ---------+-----+--------------------------------------------+----------------
//   item     | in  | op, pos_x, pos_y, pos_z, energy            | valid && ready
//   result   | out | cluster, angle, match count, best hit      | valid && ready
//   cfg      | in  | index, data (register write)               | valid && ready
//
// A clear or an add item is taken without leaving the idle state. For a cluster
// item the angle unit (28 square root steps plus 18 rotation steps) runs once
// for the cluster and, if a hit was kept, once more for that hit; each stored
// hit costs a table read plus the divider, except that a hit at the target z
// skips the divider.
// Reset clears the table fill count and loads the register defaults; the
// table contents themselves are not cleared and are never read before written.
// A finished result waits in the output register while new items are taken;
// the next cluster result only waits for that register to drain.
module tracker_calorimeter_hit_matcher #(
	parameter int MAX_TRACKER_HITS = thcm_pkg::DEF_MAX_HITS
) (
	input  logic       clk,
	input  logic       arst_n,
	thcm_in_if.sink    item,
	thcm_out_if.source result,
	thcm_cfg_if.sink   cfg
);
	import thcm_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Register writes must be issued only while the block is idle; the block does
	// not enforce this, and the port's ready is tied high.
	assign cfg.ready = 1'b1;

	// The controller owns the handshake on the item side and drives the
	// datapath step by step through cmd.
	thcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_op    (item.op),
		.in_ready (item.ready),
		.cmd      (cmd),
		.stat     (stat)
	);

	// The datapath holds the hit table, the arithmetic units and the result
	// register that feeds the output channel.
	thcm_dp #(
		.MAX_HITS (MAX_TRACKER_HITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.in_op          (item.op),
		.in_x           (item.pos_x),
		.in_y           (item.pos_y),
		.in_z           (item.pos_z),
		.in_energy      (item.energy),
		.cfg_we         (cfg.valid && cfg.ready),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.out_ready      (result.ready),
		.out_valid      (result.valid),
		.cluster_x      (result.cluster_x),
		.cluster_y      (result.cluster_y),
		.cluster_energy (result.cluster_energy),
		.cluster_angle  (result.cluster_angle),
		.matched        (result.matched),
		.window_count   (result.window_count),
		.best_index     (result.best_index),
		.track_angle    (result.track_angle),
		.projected_x    (result.projected_x),
		.projected_y    (result.projected_y)
	);

	// After a cluster item is taken, the item side is not ready while the block works on it.
	a_cluster_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && item.op == OP_CLUSTER |=> !item.ready)
		else $error("item taken right after a cluster item");

	// The match flag follows the window count.
	a_match_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.matched == (result.window_count != '0)))
		else $error("match flag disagrees with window count");

	// Without a hit in the window no hit can have been kept.
	a_no_best: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.matched |-> result.best_index == '0
			&& result.track_angle == '0 && result.projected_x == '0
			&& result.projected_y == '0)
		else $error("best hit reported without a match");

	// Angles stay within their clamped range.
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.cluster_angle <= ANGLE_MAX
			&& result.track_angle <= ANGLE_MAX)
		else $error("angle out of range");

endmodule

/* tb/tb_thcm_sb.sv */
`timescale 1ns / 1ps
// Scoreboard for the hit matcher: a bit-exact predictor of the tracker table,
// the registers and the cluster results, plus the queue of pending results.
// Depends on thcm_pkg.
class thcm_match_sb;
	typedef struct packed {
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic [15:0]        energy;
		logic [18:0]        cangle;
		logic               matched;
		logic [7:0]         count;
		logic [6:0]         best;
		logic [18:0]        tangle;
		logic signed [15:0] px;
		logic signed [15:0] py;
	} cluster_res_t;

	longint hit_x[128];
	longint hit_y[128];
	longint hit_z[128];
	int hit_fill;
	longint tgt_z, calo_z, window, max_dist;
	cluster_res_t pending[$];
	int errors;

	function new();
		hit_fill = 0;
		tgt_z = -48000;
		calo_z = 42400;
		window = 640;
		max_dist = 16000;
		errors = 0;
	endfunction

	function void write_reg(thcm_pkg::cfg_idx_t idx, logic [16:0] val);
		case (idx)
			thcm_pkg::CFG_TARGET_Z: tgt_z = longint'($signed(val));
			thcm_pkg::CFG_CALO_Z:   calo_z = longint'($signed(val));
			thcm_pkg::CFG_WINDOW:   window = longint'(val[13:0]);
			default:                max_dist = longint'(val[15:0]);
		endcase
	endfunction

	static function longint root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return longint'(r);
	endfunction

	static function longint polar(longint unsigned sumsq, longint dz);
		longint atn[18] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
		longint x, y, z, sx, sy;
		if (dz < 0 || sumsq == 0) return 0;
		if (dz == 0) return 368640;
		x = dz <<< 24;
		y = root_floor(sumsq << 16) <<< 16;
		z = 0;
		for (int i = 0; i < 18; i++) begin
			sx = y >>> i;
			sy = x >>> i;
			if (y >= 0) begin
				x += sx; y -= sy; z += atn[i];
			end else begin
				x -= sx; y += sy; z -= atn[i];
			end
		end
		if (z < 0) return 0;
		z = (z + 8) >>> 4;
		return z > 368640 ? 368640 : z;
	endfunction

	static function logic [15:0] clamp16(longint v);
		if (v > 32767) return 16'h7fff;
		if (v < -32768) return 16'h8000;
		return v[15:0];
	endfunction

	// Notes an accepted item and queues the result that it causes, if any.
	function void note_item(thcm_pkg::op_t op, logic [15:0] x, logic [15:0] y,
			logic [16:0] z, logic [15:0] e);
		cluster_res_t r;
		longint cx, cy, dzc, den, px, py, ex, ey, bpx, bpy;
		longint unsigned s, best_s;
		int cnt, best;
		bit found;
		if (op == thcm_pkg::OP_CLEAR) begin
			hit_fill = 0;
			return;
		end
		if (op == thcm_pkg::OP_ADD) begin
			if (hit_fill < 128) begin
				hit_x[hit_fill] = longint'($signed(x));
				hit_y[hit_fill] = longint'($signed(y));
				hit_z[hit_fill] = longint'($signed(z));
				hit_fill++;
			end
			return;
		end
		if (op != thcm_pkg::OP_CLUSTER) return;
		cx = longint'($signed(x)) * 10;
		cy = longint'($signed(y)) * 10;
		dzc = calo_z - tgt_z;
		best_s = max_dist * max_dist;
		cnt = 0; best = 0; found = 0; bpx = 0; bpy = 0;
		for (int i = 0; i < hit_fill; i++) begin
			den = hit_z[i] - tgt_z;
			if (den == 0) continue;
			px = hit_x[i] * dzc / den;
			py = hit_y[i] * dzc / den;
			ex = px - cx;
			ey = py - cy;
			if (ex < 0) ex = -ex;
			if (ey < 0) ey = -ey;
			if (ex >= window || ey >= window) continue;
			cnt++;
			s = ex * ex + ey * ey;
			if (s < best_s) begin
				best_s = s; best = i; found = 1; bpx = px; bpy = py;
			end
		end
		r.cx = clamp16(cx);
		r.cy = clamp16(cy);
		r.energy = e;
		r.cangle = 19'(polar(cx * cx + cy * cy, dzc));
		r.matched = cnt != 0;
		r.count = cnt > 255 ? 8'd255 : 8'(cnt);
		r.best = found ? 7'(best) : 7'd0;
		r.tangle = found ? 19'(polar(hit_x[best] * hit_x[best] + hit_y[best] * hit_y[best],
			hit_z[best] - tgt_z)) : 19'd0;
		r.px = clamp16(bpx);
		r.py = clamp16(bpy);
		pending.push_back(r);
	endfunction

	// Compares one accepted result with the oldest expectation.
	function void check_result(cluster_res_t got);
		cluster_res_t exp_r;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %p", $time, got);
			errors++;
			return;
		end
		exp_r = pending.pop_front();
		if (got.cx !== exp_r.cx) report("cluster_x", exp_r.cx, got.cx);
		if (got.cy !== exp_r.cy) report("cluster_y", exp_r.cy, got.cy);
		if (got.energy !== exp_r.energy) report("cluster_energy", exp_r.energy, got.energy);
		if (got.cangle !== exp_r.cangle) report("cluster_angle", exp_r.cangle, got.cangle);
		if (got.matched !== exp_r.matched) report("matched", exp_r.matched, got.matched);
		if (got.count !== exp_r.count) report("window_count", exp_r.count, got.count);
		if (got.best !== exp_r.best) report("best_index", exp_r.best, got.best);
		if (got.tangle !== exp_r.tangle) report("track_angle", exp_r.tangle, got.tangle);
		if (got.px !== exp_r.px) report("projected_x", exp_r.px, got.px);
		if (got.py !== exp_r.py) report("projected_y", exp_r.py, got.py);
	endfunction

	function void report(string field, logic [18:0] exp_v, logic [18:0] act_v);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
		errors++;
	endfunction
endclass

/* tb/tb.sv */
`timescale 1ns / 1ps
// Top-level testbench of the tracker / calorimeter hit matcher: drives items,
// register writes and result back-pressure, and checks through thcm_match_sb.
// Depends on thcm_pkg, thcm_if, tb_thcm_sb and the block's RTL.
module tb;
	import thcm_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	thcm_in_if  item_ch();
	thcm_out_if res_ch();
	thcm_cfg_if cfg_ch();

	tracker_calorimeter_hit_matcher i_dut (
		.clk(clk), .arst_n(arst_n), .item(item_ch.sink), .result(res_ch.source),
		.cfg(cfg_ch.sink)
	);

	thcm_match_sb sb = new();

	// Drain-side stall mode: 0 mostly ready, 1 heavy stalls, 2 always ready.
	int sink_mode = 0;
	bit sink_stop = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Idle gap: mostly none or short, sometimes long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Result side: a random ready pattern, checked at every accepting edge.
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready)
			sb.check_result({res_ch.cluster_x, res_ch.cluster_y, res_ch.cluster_energy,
				res_ch.cluster_angle, res_ch.matched, res_ch.window_count,
				res_ch.best_index, res_ch.track_angle, res_ch.projected_x,
				res_ch.projected_y});
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else if (sink_mode == 2)
			res_ch.ready <= 1'b1;
		else if (sink_mode == 1)
			res_ch.ready <= ($urandom_range(0, 9) < 2);
		else
			res_ch.ready <= ($urandom_range(0, 9) < 8);
	end

	// Sends one item, with an optional gap first, and holds it until taken.
	// Valid stays high afterwards so that items can follow back to back.
	task automatic send_item(op_t op, logic [15:0] x, logic [15:0] y, logic [16:0] z,
			logic [15:0] e);
		int g;
		g = gap_len();
		if (g != 0) begin
			item_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.op <= op;
		item_ch.pos_x <= x;
		item_ch.pos_y <= y;
		item_ch.pos_z <= z;
		item_ch.energy <= e;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_item(op, x, y, z, e);
	endtask

	// Drops valid on the item side and waits for a clock edge.
	task automatic item_idle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits for every pending result, then lets the block settle before a write.
	task automatic drain();
		item_idle();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [16:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, val);
	endtask

	task automatic write_all(logic [16:0] tz, logic [16:0] cz, logic [16:0] win,
			logic [16:0] md);
		drain();
		write_reg(CFG_TARGET_Z, tz);
		write_reg(CFG_CALO_Z, cz);
		write_reg(CFG_WINDOW, win);
		write_reg(CFG_MAX_DIST, md);
		cfg_ch.valid <= 1'b0;
	endtask

	// A random tracker hit near the beam so that projections land in the window
	// often; sometimes a full-range hit or one sitting at the target.
	task automatic add_hit(logic [15:0] cxs, logic [15:0] cys);
		int r;
		logic [15:0] x, y;
		logic [16:0] z;
		r = $urandom_range(0, 9);
		z = 17'($urandom_range(0, 131071));
		if (r < 6) begin
			z = 17'(sb.tgt_z + (sb.calo_z - sb.tgt_z) / 2
				+ $signed(17'($urandom_range(0, 2000))) - 1000);
			x = 16'(($signed(cxs) * 5) + $signed(16'($urandom_range(0, 400))) - 200);
			y = 16'(($signed(cys) * 5) + $signed(16'($urandom_range(0, 400))) - 200);
		end else if (r < 7) begin
			z = 17'(sb.tgt_z);
			x = 16'($urandom);
			y = 16'($urandom);
		end else begin
			x = 16'($urandom);
			y = 16'($urandom);
		end
		send_item(OP_ADD, x, y, z, 16'($urandom));
	endtask

	// One event: a clear, some hits, then a few clusters aimed near them.
	task automatic send_event(output int n_items);
		int nh, nc;
		logic [15:0] cxs, cys;
		cxs = 16'($signed(16'($urandom_range(0, 1200))) - 600);
		cys = 16'($signed(16'($urandom_range(0, 1200))) - 600);
		send_item(OP_CLEAR, 16'($urandom), 16'($urandom), 17'($urandom), 16'($urandom));
		nh = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 140) : $urandom_range(0, 8);
		for (int i = 0; i < nh; i++) add_hit(cxs, cys);
		nc = $urandom_range(1, 3);
		for (int i = 0; i < nc; i++)
			send_item(OP_CLUSTER, 16'($signed(cxs) + $signed(16'($urandom_range(0, 20))) - 10),
				16'($signed(cys) + $signed(16'($urandom_range(0, 20))) - 10), 17'($urandom),
				16'($urandom));
		n_items = 1 + nh + nc;
	endtask

	initial begin
		int sent, n;
		item_ch.valid = 1'b0;
		item_ch.op = OP_CLEAR;
		item_ch.pos_x = '0;
		item_ch.pos_y = '0;
		item_ch.pos_z = '0;
		item_ch.energy = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_TARGET_Z;
		cfg_ch.data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset register values.
		send_item(OP_CLUSTER, 16'h0000, 16'h0000, 17'h0, 16'h0000);
		send_item(OP_CLUSTER, 16'h7fff, 16'h8000, 17'h1ffff, 16'hffff);
		send_item(OP_ADD, 16'd0, 16'd0, 17'(-48000), 16'h0);       // hit at target z
		send_item(OP_ADD, 16'd100, 16'd50, 17'(-2800), 16'h0);
		send_item(OP_ADD, 16'd100, 16'd50, 17'(-2800), 16'h0);     // tie: first one wins
		send_item(OP_ADD, 16'h7fff, 16'h8000, 17'h0ffff, 16'h0);
		send_item(OP_ADD, 16'h8000, 16'h7fff, 17'h10000, 16'h0);   // behind the target
		send_item(OP_CLUSTER, 16'd19, 16'd9, 17'h0, 16'd1234);
		send_item(OP_CLUSTER, 16'h7fff, 16'h7fff, 17'h0, 16'd1);
		send_item(OP_NONE, 16'd5, 16'd5, 17'd5, 16'd5);             // ignored op
		send_item(OP_CLEAR, 16'h0, 16'h0, 17'h0, 16'h0);
		send_item(OP_CLUSTER, 16'd19, 16'd9, 17'h0, 16'd7);
		// Table overflow: the extra hits are dropped.
		for (int i = 0; i < 130; i++)
			send_item(OP_ADD, 16'(i), 16'(-i), 17'(-2800), 16'h0);
		send_item(OP_CLUSTER, 16'd6, 16'd0, 17'h0, 16'd9);

		// Extreme register settings: equal planes, reversed planes, full window.
		write_all(17'h0, 17'h0, 17'h3fff, 17'hffff);
		send_item(OP_CLEAR, 16'h0, 16'h0, 17'h0, 16'h0);
		send_item(OP_ADD, 16'd3, 16'd4, 17'h0, 16'h0);
		send_item(OP_ADD, 16'd3, 16'd4, 17'd100, 16'h0);
		send_item(OP_CLUSTER, 16'd0, 16'd0, 17'h0, 16'd3);
		write_all(17'h0ffff, 17'h10000, 17'h0, 17'h0);
		send_item(OP_ADD, 16'h8000, 16'h8000, 17'h10000, 16'h0);
		send_item(OP_CLUSTER, 16'h8000, 16'h8000, 17'h0, 16'd3);

		// Random events over several register settings.
		sent = 0;
		for (int phase = 0; phase < 8; phase++) begin
			sink_mode = phase % 3;
			case (phase)
				0: write_all(17'(-48000), 17'd42400, 17'd640, 17'd16000);
				1: write_all(17'(-65536), 17'd65535, 17'd16383, 17'd65535);
				2: write_all(17'(-48000), 17'd42400, 17'd0, 17'd16000);
				3: write_all(17'(-48000), 17'd42400, 17'd2000, 17'd0);
				default: write_all(17'(-$urandom_range(10000, 65536)),
					17'($urandom_range(0, 65535)), 17'($urandom_range(0, 16383)),
					17'($urandom_range(0, 65535)));
			endcase
			while (sent < (phase + 1) * 162) begin
				send_event(n);
				sent += n;
				if ($urandom_range(0, 30) == 0) begin
					item_idle();
					while (sb.pending.size() != 0) @(posedge clk);
				end
			end
		end

		sink_mode = 0;
		item_idle();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin
		#80ms;
		$display("tb NOT OK");
		$finish;
	end
endmodule
